// ===== rtl/nns_pkg.sv =====
// Shared types, sizes and helper functions for the nearest-neighbor scaler.
// Used by every module of the block but nns_ram and nns_checker; depends on nothing.
package nns_pkg;

   // Helpers for elaboration-time sizing
   function automatic int clog2_min1(input int v);
      return (v <= 2) ? 1 : $clog2(v);
   endfunction

   function automatic int nns_max(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Block dimensions
   localparam int MAX_SOURCE_ROWS = 256;
   localparam int MAX_SOURCE_COLS = 256;
   localparam int MAX_TARGET_DIM  = 4096;
   localparam int PIXEL_BITS      = 24;

   // Field and register widths
   localparam int SRC_SIZE_BITS   = 9;
   localparam int TGT_SIZE_BITS   = 13;
   localparam int IDX_BITS        = 12;
   localparam int PIX_PORT_BITS   = 24;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;

   localparam logic [SRC_SIZE_BITS-1:0] SRC_SIZE_RESET = SRC_SIZE_BITS'(256);
   localparam logic [TGT_SIZE_BITS-1:0] TGT_SIZE_RESET = TGT_SIZE_BITS'(256);

   // Pixel store
   localparam int STORE_DEPTH = MAX_SOURCE_ROWS * MAX_SOURCE_COLS;
   localparam int ADDR_BITS   = clog2_min1(STORE_DEPTH);

   // Coordinate mapping unit
   localparam int MAP_SRC_MAX = nns_max(MAX_SOURCE_ROWS, MAX_SOURCE_COLS);
   localparam int MAP_Q_BITS  = clog2_min1(MAP_SRC_MAX);

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SOURCE_ROWS = 2'd0,
      CSR_SOURCE_COLS = 2'd1,
      CSR_TARGET_ROWS = 2'd2,
      CSR_TARGET_COLS = 2'd3
   } nns_csr_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } nns_op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MAP,
      BK_SEND
   } nns_bk_state_type;

   typedef struct packed {
      nns_op_type                op;
      logic [IDX_BITS-1:0]       row;
      logic [IDX_BITS-1:0]       col;
      logic [PIXEL_BITS-1:0]     pixel;
   } nns_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } nns_qstat_type;

   typedef struct packed {
      logic [SRC_SIZE_BITS-1:0] src_rows;
      logic [SRC_SIZE_BITS-1:0] src_cols;
      logic [TGT_SIZE_BITS-1:0] tgt_rows;
      logic [TGT_SIZE_BITS-1:0] tgt_cols;
   } nns_size_type;

   // Saturate a source size to 1..hi
   function automatic logic [SRC_SIZE_BITS-1:0] sat_src(
      input logic [SRC_SIZE_BITS-1:0] v, input int hi);
      logic [SRC_SIZE_BITS-1:0] r;
      r = v;
      if (v == '0) r = SRC_SIZE_BITS'(1);
      else if (int'(v) > hi) r = SRC_SIZE_BITS'(hi);
      return r;
   endfunction

   // Saturate a target size to 1..hi
   function automatic logic [TGT_SIZE_BITS-1:0] sat_tgt(
      input logic [TGT_SIZE_BITS-1:0] v, input int hi);
      logic [TGT_SIZE_BITS-1:0] r;
      r = v;
      if (v == '0) r = TGT_SIZE_BITS'(1);
      else if (int'(v) > hi) r = TGT_SIZE_BITS'(hi);
      return r;
   endfunction

endpackage

// ===== rtl/nns_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module nns_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/nns_map.sv =====
// Coordinate mapper: floor((2*S*i + D) / (2*D)) clamped to S-1, by a
// restoring divider that resolves one quotient bit per cycle. Uses nns_pkg.
module nns_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [nns_pkg::SRC_SIZE_BITS-1:0]   size,
   input  logic [nns_pkg::TGT_SIZE_BITS-1:0]   dim,
   input  logic [nns_pkg::IDX_BITS-1:0]        idx,
   output logic                                done,
   output logic [nns_pkg::MAP_Q_BITS-1:0]      coord
);
   import nns_pkg::*;

   localparam int PROD_BITS = SRC_SIZE_BITS + IDX_BITS;
   localparam int NUM_BITS  = PROD_BITS + 1;
   localparam int DEN_BITS  = TGT_SIZE_BITS + 1;
   localparam int LIM_BITS  = SRC_SIZE_BITS + DEN_BITS;
   localparam int SH_BITS   = DEN_BITS + MAP_Q_BITS - 1;
   localparam int WIDE_BITS = nns_max(nns_max(NUM_BITS, LIM_BITS), SH_BITS);
   localparam int STEP_BITS = clog2_min1(MAP_Q_BITS);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [NUM_BITS-1:0]   rem_ff, rem_in;
   logic [LIM_BITS-1:0]   lim_ff, lim_in;
   logic [SH_BITS-1:0]    sh_ff, sh_in;
   logic [MAP_Q_BITS-1:0] q_ff, q_in;
   logic                  over_ff, over_in;
   logic [MAP_Q_BITS-1:0] last_ff, last_in;

   logic [PROD_BITS-1:0]  prod_w;
   logic [NUM_BITS-1:0]   num_w;
   logic [DEN_BITS-1:0]   den2_w;
   logic [SRC_SIZE_BITS-1:0] size_m1_w;
   logic                  fits_w;
   logic [WIDE_BITS-1:0]  diff_w;
   logic [MAP_Q_BITS:0]   q_cat_w;
   logic                  first_w;
   logic                  final_w;

   // Operands formed at start
   assign prod_w    = PROD_BITS'(size) * PROD_BITS'(idx);
   assign num_w     = {prod_w, 1'b0} + NUM_BITS'(dim);
   assign den2_w    = {dim, 1'b0};
   assign size_m1_w = size - SRC_SIZE_BITS'(1);

   // One restoring step
   assign fits_w  = WIDE_BITS'(rem_ff) >= WIDE_BITS'(sh_ff);
   assign diff_w  = WIDE_BITS'(rem_ff) - WIDE_BITS'(sh_ff);
   assign q_cat_w = {q_ff, fits_w};
   assign first_w = run_ff && (step_ff == STEP_BITS'(MAP_Q_BITS - 1));
   assign final_w = run_ff && (step_ff == '0);

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      lim_in  = lim_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      over_in = over_ff;
      last_in = last_ff;
      done_in = final_w;
      if (start) begin
         // load the dividend, the clamp limit and the aligned divisor
         run_in  = 1'b1;
         step_in = STEP_BITS'(MAP_Q_BITS - 1);
         rem_in  = num_w;
         lim_in  = LIM_BITS'(size) * LIM_BITS'(den2_w);
         sh_in   = SH_BITS'(den2_w) << (MAP_Q_BITS - 1);
         q_in    = '0;
         last_in = MAP_Q_BITS'(size_m1_w);
      end else if (run_ff) begin
         // resolve one quotient bit, note on the first step if we clamp
         if (fits_w) begin
            rem_in = NUM_BITS'(diff_w);
         end
         q_in  = q_cat_w[MAP_Q_BITS-1:0];
         sh_in = sh_ff >> 1;
         if (first_w) begin
            over_in = WIDE_BITS'(rem_ff) >= WIDE_BITS'(lim_ff);
         end
         if (final_w) begin
            run_in = 1'b0;
         end else begin
            step_in = step_ff - STEP_BITS'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      lim_ff  <= lim_in;
      sh_ff   <= sh_in;
      q_ff    <= q_in;
      over_ff <= over_in;
      last_ff <= last_in;
   end

   assign done  = done_ff;
   assign coord = over_ff ? last_ff : q_ff;

endmodule

// ===== rtl/nns_queue.sv =====
// Short request queue between the front end and the back end.
// Uses nns_pkg for the item and status types.
module nns_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  nns_pkg::nns_item_type  push_item,
   input  logic                   pop,
   output nns_pkg::nns_item_type  head_item,
   output nns_pkg::nns_qstat_type qstat
);
   import nns_pkg::*;

   localparam int PTR_BITS = clog2_min1(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   nns_item_type          items_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         items_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item   = items_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

// ===== rtl/nns_front.sv =====
// Front end: accepts requests, drops loads outside the source size and
// queues the rest. Uses nns_pkg.
module nns_front (
   input  logic                                start,
   input  logic                                req_mode,
   input  logic [nns_pkg::IDX_BITS-1:0]        req_row_index,
   input  logic [nns_pkg::IDX_BITS-1:0]        req_col_index,
   input  logic [nns_pkg::PIX_PORT_BITS-1:0]   req_pixel_in,
   input  nns_pkg::nns_size_type               sizes,
   input  nns_pkg::nns_qstat_type              qstat,
   output logic                                busy,
   output logic                                push,
   output nns_pkg::nns_item_type               push_item
);
   import nns_pkg::*;

   logic accept_w;
   logic in_range_w;

   assign busy     = qstat.full;
   assign accept_w = start && !qstat.full;

   // Classify: loads outside the source image are dropped here
   assign in_range_w = (req_row_index < IDX_BITS'(sizes.src_rows)) &&
                       (req_col_index < IDX_BITS'(sizes.src_cols));

   assign push = accept_w && ((nns_op_type'(req_mode) == OP_FETCH) || in_range_w);

   assign push_item.op    = nns_op_type'(req_mode);
   assign push_item.row   = req_row_index;
   assign push_item.col   = req_col_index;
   assign push_item.pixel = PIXEL_BITS'(req_pixel_in);

endmodule

// ===== rtl/nns_back.sv =====
// Back end: writes loads into the pixel store and runs fetches through the
// two coordinate mappers and a store read. Uses nns_pkg, nns_map, nns_ram.
module nns_back (
   input  logic                                clock,
   input  logic                                reset,
   input  nns_pkg::nns_size_type               sizes,
   input  nns_pkg::nns_qstat_type              qstat,
   input  nns_pkg::nns_item_type               head_item,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic [nns_pkg::PIX_PORT_BITS-1:0]   rsp_pixel_out
);
   import nns_pkg::*;

   nns_bk_state_type        state_ff, state_in;
   logic                    map_start;
   logic                    ram_we;
   logic                    ram_re;
   logic                    row_done;
   logic                    col_done;
   logic [MAP_Q_BITS-1:0]   row_coord;
   logic [MAP_Q_BITS-1:0]   col_coord;
   logic [ADDR_BITS-1:0]    waddr;
   logic [ADDR_BITS-1:0]    raddr;
   logic [PIXEL_BITS-1:0]   rdata;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty && head_item.op == OP_FETCH) state_in = BK_MAP;
         end
         BK_MAP: begin
            if (row_done && col_done) state_in = BK_SEND;
         end
         BK_SEND: begin
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      pop       = 1'b0;
      map_start = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop       = !qstat.empty;
            map_start = !qstat.empty && (head_item.op == OP_FETCH);
            ram_we    = !qstat.empty && (head_item.op == OP_LOAD);
         end
         BK_MAP: begin
            ram_re = row_done && col_done;
         end
         BK_SEND: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Row and column mapping run side by side
   nns_map u_row_map (
      .clock (clock),
      .reset (reset),
      .start (map_start),
      .size  (sizes.src_rows),
      .dim   (sizes.tgt_rows),
      .idx   (head_item.row),
      .done  (row_done),
      .coord (row_coord)
   );

   nns_map u_col_map (
      .clock (clock),
      .reset (reset),
      .start (map_start),
      .size  (sizes.src_cols),
      .dim   (sizes.tgt_cols),
      .idx   (head_item.col),
      .done  (col_done),
      .coord (col_coord)
   );

   // Store addresses, row-major
   assign waddr = ADDR_BITS'(ADDR_BITS'(head_item.row) * ADDR_BITS'(MAX_SOURCE_COLS) +
                             ADDR_BITS'(head_item.col));
   assign raddr = ADDR_BITS'(ADDR_BITS'(row_coord) * ADDR_BITS'(MAX_SOURCE_COLS) +
                             ADDR_BITS'(col_coord));

   nns_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr),
      .wdata (head_item.pixel),
      .re    (ram_re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp_pixel_out = PIX_PORT_BITS'(rdata);

endmodule

// ===== rtl/nearest_neighbor_scaler_core.sv =====
// Top level of the nearest-neighbor scaler: size registers, front end,
// request queue and back end. Uses nns_pkg, nns_front, nns_queue, nns_back.
//
// A request is taken when start is high and busy is low. A load (mode 0)
// writes one source pixel and gives no response; loads outside the
// configured source size are dropped. A fetch (mode 1) maps the destination
// row and column to the nearest source pixel with half-up rounding, clamps
// to the last source row/column, and returns that pixel on rsp_pixel_out
// for exactly one cycle with rsp_valid high; the receiver cannot stall it.
// A two-entry queue decouples intake from execution, so busy rises only
// when both entries are taken. The back end retires a load from its idle
// state and runs a fetch through these steps: start the restoring dividers
// (one quotient bit per cycle, row and column in parallel), read the
// pixel store and present the response. The pixel store is not
// cleared at reset; fetching a pixel that was never loaded returns an
// undefined value. Change the size registers only while the block is idle.
module nearest_neighbor_scaler_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic [nns_pkg::IDX_BITS-1:0]         req_row_index,
   input  logic [nns_pkg::IDX_BITS-1:0]         req_col_index,
   input  logic [nns_pkg::PIX_PORT_BITS-1:0]    req_pixel_in,
   output logic                                 rsp_valid,
   output logic [nns_pkg::PIX_PORT_BITS-1:0]    rsp_pixel_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nns_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [nns_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import nns_pkg::*;

   logic [SRC_SIZE_BITS-1:0] src_rows_ff, src_rows_in;
   logic [SRC_SIZE_BITS-1:0] src_cols_ff, src_cols_in;
   logic [TGT_SIZE_BITS-1:0] tgt_rows_ff, tgt_rows_in;
   logic [TGT_SIZE_BITS-1:0] tgt_cols_ff, tgt_cols_in;
   nns_size_type             sizes;
   nns_qstat_type            qstat;
   nns_item_type             push_item;
   nns_item_type             head_item;
   logic                     push;
   logic                     pop;

   assign csr_ready = 1'b1;

   // Size register writes
   always_comb begin
      src_rows_in = src_rows_ff;
      src_cols_in = src_cols_ff;
      tgt_rows_in = tgt_rows_ff;
      tgt_cols_in = tgt_cols_ff;
      if (csr_valid) begin
         unique case (nns_csr_type'(csr_index))
            CSR_SOURCE_ROWS: src_rows_in = csr_data[SRC_SIZE_BITS-1:0];
            CSR_SOURCE_COLS: src_cols_in = csr_data[SRC_SIZE_BITS-1:0];
            CSR_TARGET_ROWS: tgt_rows_in = csr_data[TGT_SIZE_BITS-1:0];
            CSR_TARGET_COLS: tgt_cols_in = csr_data[TGT_SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_rows_ff <= SRC_SIZE_RESET;
         src_cols_ff <= SRC_SIZE_RESET;
         tgt_rows_ff <= TGT_SIZE_RESET;
         tgt_cols_ff <= TGT_SIZE_RESET;
      end else begin
         src_rows_ff <= src_rows_in;
         src_cols_ff <= src_cols_in;
         tgt_rows_ff <= tgt_rows_in;
         tgt_cols_ff <= tgt_cols_in;
      end
   end

   // Effective sizes, saturated to their legal ranges
   assign sizes.src_rows = sat_src(src_rows_ff, MAX_SOURCE_ROWS);
   assign sizes.src_cols = sat_src(src_cols_ff, MAX_SOURCE_COLS);
   assign sizes.tgt_rows = sat_tgt(tgt_rows_ff, MAX_TARGET_DIM);
   assign sizes.tgt_cols = sat_tgt(tgt_cols_ff, MAX_TARGET_DIM);

   nns_front u_front (
      .start         (start),
      .req_mode      (req_mode),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_pixel_in  (req_pixel_in),
      .sizes         (sizes),
      .qstat         (qstat),
      .busy          (busy),
      .push          (push),
      .push_item     (push_item)
   );

   nns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   nns_back u_back (
      .clock         (clock),
      .reset         (reset),
      .sizes         (sizes),
      .qstat         (qstat),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out)
   );

endmodule

// ===== rtl/nns_checker.sv =====
// Port-level checks for the nearest-neighbor scaler top level, and the bind
// that attaches them. Depends only on the top level's ports.
module nns_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Responses come from one fetch at a time, so they are spaced apart
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("response strobes too close together");

   // Reset leaves no response pending and the queue empty
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("response or busy right after reset");

   // The queue fills only through an accepted request
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !reset))
      else $error("busy rose without a request");

endmodule

bind nearest_neighbor_scaler_core nns_checker u_nns_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// ===== test/testbench.sv =====
// Self-checking testbench for nearest_neighbor_scaler_core: loads source pixels,
// fetches scaled positions and compares each response with a predicted pixel.
// Depends on nns_pkg and the nearest_neighbor_scaler_core RTL.
module testbench;
   import nns_pkg::*;

   localparam int DRAIN_CYCLES     = 40;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int NUM_PHASES       = 10;
   localparam int ITEMS_PER_PHASE  = 82;

   // Predicts scaled pixels from a private copy of the sizes and the store
   class scaler_scoreboard;
      logic [PIXEL_BITS-1:0]    pixels [STORE_DEPTH];
      bit                       loaded [STORE_DEPTH];
      logic [SRC_SIZE_BITS-1:0] src_rows = SRC_SIZE_RESET;
      logic [SRC_SIZE_BITS-1:0] src_cols = SRC_SIZE_RESET;
      logic [TGT_SIZE_BITS-1:0] tgt_rows = TGT_SIZE_RESET;
      logic [TGT_SIZE_BITS-1:0] tgt_cols = TGT_SIZE_RESET;
      logic [PIX_PORT_BITS-1:0] expected_pixels [$];
      int                       errors = 0;

      function int unsigned saturate(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned eff_src_rows();
         return saturate(src_rows, MAX_SOURCE_ROWS);
      endfunction

      function int unsigned eff_src_cols();
         return saturate(src_cols, MAX_SOURCE_COLS);
      endfunction

      function int unsigned eff_tgt_rows();
         return saturate(tgt_rows, MAX_TARGET_DIM);
      endfunction

      function int unsigned eff_tgt_cols();
         return saturate(tgt_cols, MAX_TARGET_DIM);
      endfunction

      // Half-up nearest source coordinate, clamped to the last one
      function int unsigned map_coord(int unsigned s, int unsigned d, int unsigned i);
         int unsigned q;
         q = (2 * s * i + d) / (2 * d);
         if (q > s - 1) q = s - 1;
         return q;
      endfunction

      function int unsigned source_addr(logic [IDX_BITS-1:0] row, logic [IDX_BITS-1:0] col);
         return map_coord(eff_src_rows(), eff_tgt_rows(), row) * MAX_SOURCE_COLS
              + map_coord(eff_src_cols(), eff_tgt_cols(), col);
      endfunction

      function void set_register(nns_csr_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_SOURCE_ROWS: src_rows = data[SRC_SIZE_BITS-1:0];
            CSR_SOURCE_COLS: src_cols = data[SRC_SIZE_BITS-1:0];
            CSR_TARGET_ROWS: tgt_rows = data[TGT_SIZE_BITS-1:0];
            CSR_TARGET_COLS: tgt_cols = data[TGT_SIZE_BITS-1:0];
         endcase
      endfunction

      // Store a load or queue the pixel a fetch must return
      function void note_request(nns_op_type op, logic [IDX_BITS-1:0] row,
                                 logic [IDX_BITS-1:0] col, logic [PIX_PORT_BITS-1:0] pix);
         int unsigned addr;
         if (op == OP_LOAD) begin
            if (row < eff_src_rows() && col < eff_src_cols()) begin
               addr = row * MAX_SOURCE_COLS + col;
               pixels[addr] = pix[PIXEL_BITS-1:0];
               loaded[addr] = 1'b1;
            end
         end else begin
            expected_pixels.push_back(PIX_PORT_BITS'(pixels[source_addr(row, col)]));
         end
      endfunction

      function void check_pixel(logic [PIX_PORT_BITS-1:0] actual);
         logic [PIX_PORT_BITS-1:0] want;
         if (expected_pixels.size() == 0) begin
            $error("unexpected response: pixel_out expected none, actual %h", actual);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (want !== actual) begin
               $error("pixel_out mismatch: expected %h, actual %h", want, actual);
               errors++;
            end
         end
      endfunction

      function int pending_count();
         return expected_pixels.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_mode;
   logic [IDX_BITS-1:0]         req_row_index;
   logic [IDX_BITS-1:0]         req_col_index;
   logic [PIX_PORT_BITS-1:0]    req_pixel_in;
   logic                        rsp_valid;
   logic [PIX_PORT_BITS-1:0]    rsp_pixel_out;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_data;

   scaler_scoreboard sb = new();
   int               idle_cycles = 0;

   nearest_neighbor_scaler_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Check every response in the cycle it is presented
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_pixel(rsp_pixel_out);
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Hold a request until the block takes it
   task automatic send_request(nns_op_type op, logic [IDX_BITS-1:0] row,
                               logic [IDX_BITS-1:0] col, logic [PIX_PORT_BITS-1:0] pix);
      start         <= 1'b1;
      req_mode      <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_pixel_in  <= pix;
      do @(posedge clock); while (busy);
      sb.note_request(op, row, col, pix);
   endtask

   // Fetch a position, loading the selected source pixel first if it is still unwritten
   task automatic fetch_pixel(logic [IDX_BITS-1:0] row, logic [IDX_BITS-1:0] col);
      int unsigned addr;
      addr = sb.source_addr(row, col);
      if (!sb.loaded[addr]) begin
         send_request(OP_LOAD, IDX_BITS'(addr / MAX_SOURCE_COLS),
                      IDX_BITS'(addr % MAX_SOURCE_COLS), PIX_PORT_BITS'($urandom));
      end
      send_request(OP_FETCH, row, col, PIX_PORT_BITS'($urandom));
   endtask

   // Drop start for a random burst now and then
   task automatic maybe_idle(bit enable);
      if (enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Wait for all responses, then let trailing loads retire
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all four size registers back to back
   task automatic write_sizes(logic [CSR_DATA_BITS-1:0] s_rows, logic [CSR_DATA_BITS-1:0] s_cols,
                              logic [CSR_DATA_BITS-1:0] t_rows, logic [CSR_DATA_BITS-1:0] t_cols);
      nns_csr_type              regs [4];
      logic [CSR_DATA_BITS-1:0] vals [4];
      regs = '{CSR_SOURCE_ROWS, CSR_SOURCE_COLS, CSR_TARGET_ROWS, CSR_TARGET_COLS};
      vals = '{s_rows, s_cols, t_rows, t_cols};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_register(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] random_src_size();
      int unsigned pick;
      logic [CSR_DATA_BITS-1:0] v;
      pick = $urandom_range(0, 9);
      if (pick < 7) v = CSR_DATA_BITS'($urandom_range(1, 16));
      else if (pick < 9) v = CSR_DATA_BITS'($urandom_range(17, 256));
      else if ($urandom_range(0, 1)) v = '0;
      else v = CSR_DATA_BITS'($urandom_range(257, 511));
      // Upper bits do not reach the 9-bit register
      v[CSR_DATA_BITS-1:SRC_SIZE_BITS] = (CSR_DATA_BITS - SRC_SIZE_BITS)'($urandom);
      return v;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_tgt_size();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return CSR_DATA_BITS'($urandom_range(1, 64));
      if (pick < 8) return CSR_DATA_BITS'($urandom_range(65, 4096));
      if ($urandom_range(0, 1)) return '0;
      return CSR_DATA_BITS'($urandom_range(4097, 8191));
   endfunction

   initial begin
      int unsigned sr;
      int unsigned sc;
      int unsigned pick;
      bit          idle_on;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;

      reset         <= 1'b1;
      start         <= 1'b0;
      req_mode      <= OP_LOAD;
      req_row_index <= '0;
      req_col_index <= '0;
      req_pixel_in  <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_SOURCE_ROWS;
      csr_data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset sizes: corner loads, loads outside the source, corner fetches
      send_request(OP_LOAD, 12'd0, 12'd0, 24'h000000);
      send_request(OP_LOAD, 12'd255, 12'd255, 24'hFFFFFF);
      send_request(OP_LOAD, 12'd0, 12'd255, 24'hA5A5A5);
      send_request(OP_LOAD, 12'd255, 12'd0, 24'h5A5A5A);
      send_request(OP_LOAD, 12'd256, 12'd0, 24'h123456);
      send_request(OP_LOAD, 12'd0, 12'd256, 24'h654321);
      send_request(OP_LOAD, 12'hFFF, 12'hFFF, 24'hFFFFFF);
      fetch_pixel(12'd0, 12'd0);
      fetch_pixel(12'd255, 12'd255);
      fetch_pixel(12'hFFF, 12'hFFF);
      fetch_pixel(12'd0, 12'hFFF);
      fetch_pixel(12'hFFF, 12'd0);

      // Smallest sizes everywhere
      drain();
      write_sizes(13'd1, 13'd1, 13'd1, 13'd1);
      send_request(OP_LOAD, 12'd0, 12'd0, PIX_PORT_BITS'($urandom));
      send_request(OP_LOAD, 12'd0, 12'd1, PIX_PORT_BITS'($urandom));
      fetch_pixel(12'd0, 12'd0);
      fetch_pixel(12'hFFF, 12'hFFF);

      // Zero and oversized register values saturate
      drain();
      write_sizes(13'd0, 13'h1FFF, 13'd0, 13'h1FFF);
      fetch_pixel(12'hFFF, 12'hFFF);
      fetch_pixel(12'd0, 12'd2048);
      fetch_pixel(12'd7, 12'd4095);

      // Largest sizes; the store from earlier phases is kept
      drain();
      write_sizes(13'd256, 13'd256, 13'd4096, 13'd4096);
      fetch_pixel(12'hFFF, 12'hFFF);
      fetch_pixel(12'd2048, 12'd2047);
      fetch_pixel(12'd0, 12'd0);

      // Random phases: new sizes, then a mix of loads and fetches
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_sizes(random_src_size(), random_src_size(), random_tgt_size(), random_tgt_size());
         sr = sb.eff_src_rows();
         sc = sb.eff_src_cols();
         idle_on = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               if ($urandom_range(0, 6) == 0) row = IDX_BITS'($urandom);
               else row = IDX_BITS'($urandom_range(0, sb.eff_tgt_rows() - 1));
               if ($urandom_range(0, 6) == 0) col = IDX_BITS'($urandom);
               else col = IDX_BITS'($urandom_range(0, sb.eff_tgt_cols() - 1));
               fetch_pixel(row, col);
            end else if (pick < 85) begin
               send_request(OP_LOAD, IDX_BITS'($urandom_range(0, sr - 1)),
                            IDX_BITS'($urandom_range(0, sc - 1)), PIX_PORT_BITS'($urandom));
            end else begin
               // Loads outside the source size must leave the store untouched
               if ($urandom_range(0, 1)) begin
                  row = IDX_BITS'($urandom_range(sr, 4095));
                  col = IDX_BITS'($urandom);
               end else begin
                  row = IDX_BITS'($urandom);
                  col = IDX_BITS'($urandom_range(sc, 4095));
               end
               send_request(OP_LOAD, row, col, PIX_PORT_BITS'($urandom));
            end
            maybe_idle(idle_on);
         end
      end

      drain();
      if (sb.pending_count() != 0) begin
         $error("pixel_out expected %0d more responses, actual none", sb.pending_count());
      end
      if (sb.errors == 0 && sb.pending_count() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/nns_pkg.sv
rtl/nns_ram.sv
rtl/nns_map.sv
rtl/nns_queue.sv
rtl/nns_front.sv
rtl/nns_back.sv
rtl/nearest_neighbor_scaler_core.sv
rtl/nns_checker.sv
test/testbench.sv
